FILE: design/trs_pkg.sv
// Package for the timestamped reading store.
// Holds the operation, status and sequencer state codes and the stored entry type.
// No dependencies.
`default_nettype none

package trs_pkg;

  typedef enum logic [1:0] {
    OP_APPEND        = 2'd0,
    OP_LOOKUP        = 2'd1,
    OP_REMOVE        = 2'd2,
    OP_REMOVE_OLDEST = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SH_RD,
    S_SH_WR,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        [31:0] time_key;
    logic signed [31:0] reading;
  } entry_t;

  localparam int TDATA_IN_W  = 64;
  localparam int TDATA_OUT_W = 40;
  localparam int COUNT_W     = 5;

endpackage

`default_nettype wire

FILE: design/timestamped_reading_store_unit.sv
// One beat at a time: an append below capacity writes the entry and then loads the result
// register; other operations first scan the n stored entries, and a deletion then closes
// the gap by reading and rewriting each later entry in turn.
// Flow: the next beat is taken once the previous result is in the output
// register; the scan reads one entry per cycle. Reset (rst, synchronous)
// empties the store at once; no clearing pass runs.
`default_nettype none

module timestamped_reading_store_unit
  import trs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // time_key, reading_in
  input  wire logic [1:0]             s_tuser,   // operation
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [TDATA_OUT_W-1:0]      m_tdata    // status, reading_out, evicted, entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  status_t       out_status;
  logic signed [31:0] out_reading;
  logic          out_evicted;
  logic [COUNT_W-1:0] out_count;
  op_t           in_op;

  assign in_op   = op_t'(s_tuser);
  assign m_tdata = {out_count, out_evicted, out_reading, out_status};

  trs_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (in_op),
    .in_key     (s_tdata[31:0]),
    .in_reading (s_tdata[63:32]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_reading(out_reading),
    .out_evicted(out_evicted),
    .out_count  (out_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  trs_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

`default_nettype wire

FILE: design/trs_mem.sv
// Entry memory of the timestamped reading store: one write port and one read port.
// Read data is registered, so it arrives in the cycle after the address.
// Depends on trs_pkg for the entry type.
`default_nettype none

module trs_mem
  import trs_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/trs_ctrl.sv
// Sequencer of the timestamped reading store: scans the entry memory, closes gaps
// left by deletions, appends entries and holds the result register.
// Depends on trs_pkg; drives the ports of trs_mem.
`default_nettype none

module trs_ctrl
  import trs_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire op_t                  in_op,
  input  wire logic        [31:0]   in_key,
  input  wire logic signed [31:0]   in_reading,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output status_t                   out_status,
  output logic signed [31:0]        out_reading,
  output logic                      out_evicted,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  wire entry_t               rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output entry_t                    wr_data
);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  state_t state, state_next;
  op_t op, op_next;
  logic [31:0] key, key_next;
  logic signed [31:0] rdg, rdg_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan_addr, scan_addr_next;
  logic rd_pend, rd_pend_next;
  logic best_found, best_found_next;
  logic [31:0] best_time, best_time_next;
  logic [CW-1:0] best_idx, best_idx_next;
  logic [CW-1:0] ptr, ptr_next;
  logic evict, evict_next;
  status_t status, status_next;
  logic signed [31:0] reading, reading_next;
  logic out_valid_next;
  logic out_load;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] found_idx;
  logic is_match_op;
  logic hit;
  logic older;
  logic finish;
  logic found;
  logic [31:0] count_w;

  assign rd_idx  = scan_addr - ONE_C;
  assign ptr_inc = ptr + ONE_C;
  assign count_w = 32'(count);

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    rdg_next        = rdg;
    count_next      = count;
    scan_addr_next  = scan_addr;
    rd_pend_next    = rd_pend;
    best_found_next = best_found;
    best_time_next  = best_time;
    best_idx_next   = best_idx;
    ptr_next        = ptr;
    evict_next      = evict;
    status_next     = status;
    reading_next    = reading;
    out_valid_next  = out_valid && !out_ready;
    out_load        = 1'b0;
    in_ready        = (state == S_IDLE);
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '{time_key: key, reading: rdg};
    is_match_op     = (op == OP_LOOKUP) || (op == OP_REMOVE);
    hit             = rd_pend && is_match_op && (rd_data.time_key == key);
    older           = rd_pend && !is_match_op &&
                      (!best_found || (rd_data.time_key < best_time));
    finish          = hit || (!rd_pend && (scan_addr == count));
    found           = hit || best_found;
    found_idx       = hit ? rd_idx : best_idx;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next         = in_op;
          key_next        = in_key;
          rdg_next        = in_reading;
          scan_addr_next  = '0;
          rd_pend_next    = 1'b0;
          best_found_next = 1'b0;
          evict_next      = 1'b0;
          status_next     = ST_DONE;
          reading_next    = '0;
          if ((in_op == OP_APPEND) && (count != CAP_C)) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_addr != count) begin
          rd_en          = 1'b1;
          rd_addr        = scan_addr[AW-1:0];
          scan_addr_next = scan_addr + ONE_C;
          rd_pend_next   = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
        end
        if (older) begin
          best_found_next = 1'b1;
          best_time_next  = rd_data.time_key;
          best_idx_next   = rd_idx;
        end
        if (finish) begin
          ptr_next = found_idx;
          case (op)
            OP_LOOKUP: begin
              if (found) begin
                reading_next = rd_data.reading;
              end else begin
                status_next = ST_NOT_FOUND;
              end
              state_next = S_DONE;
            end
            OP_REMOVE: begin
              if (found) begin
                state_next = S_SH_RD;
              end else begin
                status_next = ST_NOT_FOUND;
                state_next  = S_DONE;
              end
            end
            OP_REMOVE_OLDEST: begin
              if (found) begin
                state_next = S_SH_RD;
              end else begin
                status_next = ST_EMPTY;
                state_next  = S_DONE;
              end
            end
            default: begin
              evict_next = 1'b1;
              state_next = S_SH_RD;
            end
          endcase
        end
      end
      S_SH_RD: begin
        if (ptr_inc < count) begin
          rd_en      = 1'b1;
          rd_addr    = ptr_inc[AW-1:0];
          state_next = S_SH_WR;
        end else begin
          count_next = count - ONE_C;
          state_next = (op == OP_APPEND) ? S_WRITE : S_DONE;
        end
      end
      S_SH_WR: begin
        wr_en      = 1'b1;
        wr_addr    = ptr[AW-1:0];
        wr_data    = rd_data;
        ptr_next   = ptr_inc;
        state_next = S_SH_RD;
      end
      S_WRITE: begin
        wr_en      = 1'b1;
        wr_addr    = count[AW-1:0];
        count_next = count + ONE_C;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_load       = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd_pend    <= rd_pend_next;
      best_found <= best_found_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    key       <= key_next;
    rdg       <= rdg_next;
    scan_addr <= scan_addr_next;
    best_time <= best_time_next;
    best_idx  <= best_idx_next;
    ptr       <= ptr_next;
    evict     <= evict_next;
    status    <= status_next;
    reading   <= reading_next;
    if (out_load) begin
      out_status  <= status;
      out_reading <= reading;
      out_evicted <= evict;
      out_count   <= count_w[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/trs_checker.sv
// Port-level checks for the timestamped reading store, attached by a bind.
// Depends on trs_pkg and on the ports of timestamped_reading_store_unit.
`default_nettype none

module trs_checker
  import trs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [TDATA_OUT_W-1:0] m_tdata
);

  localparam logic [31:0] CAP_W = 32'(CAPACITY);

  logic [31:0] count_w;
  assign count_w = 32'(m_tdata[39:35]);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an operation is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CAP_W > 32'd31) || (count_w <= CAP_W))
    else $error("entry count above capacity");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_EMPTY) |-> (m_tdata[39:35] == 5'd0) &&
      (m_tdata[33:2] == 32'd0))
    else $error("empty status with entries or a reading");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> (m_tdata[1:0] == ST_DONE) &&
      ((CAP_W > 32'd31) || (count_w == CAP_W)))
    else $error("eviction reported while the store was not full");

endmodule

bind timestamped_reading_store_unit trs_checker #(
  .CAPACITY(CAPACITY)
) u_trs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire
